### hdl/seg_pkg.sv
package seg_pkg;

    localparam int COORD_W = 16;
    localparam int DELTA_W = 17;
    localparam int PROD_W = 34;
    localparam int SUM_W = 35;
    localparam int MUL_W = 52;
    localparam int FRAC_BITS = 8;
    localparam int NUM_W = MUL_W + FRAC_BITS;
    localparam int QUOT_W = 24;
    localparam int POINT_W = 24;

    localparam logic [1:0] STATUS_HIT = 2'd0;
    localparam logic [1:0] STATUS_PARALLEL = 2'd1;
    localparam logic [1:0] STATUS_MISS = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic signed [SUM_W-1:0] na;
        logic signed [SUM_W-1:0] den;
        logic signed [DELTA_W-1:0] dax;
        logic signed [DELTA_W-1:0] day;
        logic signed [COORD_W-1:0] ax0;
        logic signed [COORD_W-1:0] ay0;
    } entry_t;

endpackage

### hdl/seg_front.sv
module seg_front
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [15:0] ax0,
    input  logic signed [15:0] ay0,
    input  logic signed [15:0] ax1,
    input  logic signed [15:0] ay1,
    input  logic signed [15:0] bx0,
    input  logic signed [15:0] by0,
    input  logic signed [15:0] bx1,
    input  logic signed [15:0] by1,
    output logic push,
    output seg_pkg::entry_t push_entry,
    input  logic queue_ready
);

    logic adv;
    logic f1_valid_reg, f2_valid_reg, f3_valid_reg;

    logic signed [seg_pkg::DELTA_W-1:0] dax_reg, day_reg, dbx_reg, dby_reg, ox_reg, oy_reg;
    logic signed [seg_pkg::COORD_W-1:0] f1_ax0_reg, f1_ay0_reg;

    logic signed [seg_pkg::PROD_W-1:0] p_den0_reg, p_den1_reg;
    logic signed [seg_pkg::PROD_W-1:0] p_na0_reg, p_na1_reg;
    logic signed [seg_pkg::PROD_W-1:0] p_nb0_reg, p_nb1_reg;
    logic signed [seg_pkg::DELTA_W-1:0] f2_dax_reg, f2_day_reg;
    logic signed [seg_pkg::COORD_W-1:0] f2_ax0_reg, f2_ay0_reg;

    logic signed [seg_pkg::SUM_W-1:0] den_next, na_next, nb_next;
    logic na_ok, nb_ok;
    logic [1:0] status_next;
    seg_pkg::entry_t entry_reg, entry_next;

    assign adv = !(f3_valid_reg && !queue_ready);
    assign in_ready = adv;
    assign push = f3_valid_reg && queue_ready;
    assign push_entry = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_valid_reg <= in_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dax_reg <= {ax1[15], ax1} - {ax0[15], ax0};
            day_reg <= {ay1[15], ay1} - {ay0[15], ay0};
            dbx_reg <= {bx1[15], bx1} - {bx0[15], bx0};
            dby_reg <= {by1[15], by1} - {by0[15], by0};
            ox_reg <= {ax0[15], ax0} - {bx0[15], bx0};
            oy_reg <= {ay0[15], ay0} - {by0[15], by0};
            f1_ax0_reg <= ax0;
            f1_ay0_reg <= ay0;

            p_den0_reg <= seg_pkg::PROD_W'(dby_reg) * seg_pkg::PROD_W'(dax_reg);
            p_den1_reg <= seg_pkg::PROD_W'(dbx_reg) * seg_pkg::PROD_W'(day_reg);
            p_na0_reg <= seg_pkg::PROD_W'(dbx_reg) * seg_pkg::PROD_W'(oy_reg);
            p_na1_reg <= seg_pkg::PROD_W'(dby_reg) * seg_pkg::PROD_W'(ox_reg);
            p_nb0_reg <= seg_pkg::PROD_W'(dax_reg) * seg_pkg::PROD_W'(oy_reg);
            p_nb1_reg <= seg_pkg::PROD_W'(day_reg) * seg_pkg::PROD_W'(ox_reg);
            f2_dax_reg <= dax_reg;
            f2_day_reg <= day_reg;
            f2_ax0_reg <= f1_ax0_reg;
            f2_ay0_reg <= f1_ay0_reg;

            entry_reg <= entry_next;
        end
    end

    always_comb
    begin
        den_next = seg_pkg::SUM_W'(p_den0_reg) - seg_pkg::SUM_W'(p_den1_reg);
        na_next = seg_pkg::SUM_W'(p_na0_reg) - seg_pkg::SUM_W'(p_na1_reg);
        nb_next = seg_pkg::SUM_W'(p_nb0_reg) - seg_pkg::SUM_W'(p_nb1_reg);
        if (den_next > 0)
        begin
            na_ok = (na_next >= 0) && (na_next <= den_next);
            nb_ok = (nb_next >= 0) && (nb_next <= den_next);
        end
        else
        begin
            na_ok = (na_next <= 0) && (na_next >= den_next);
            nb_ok = (nb_next <= 0) && (nb_next >= den_next);
        end
        if (den_next == 0)
            status_next = seg_pkg::STATUS_PARALLEL;
        else if (na_ok && nb_ok)
            status_next = seg_pkg::STATUS_HIT;
        else
            status_next = seg_pkg::STATUS_MISS;
        entry_next.status = status_next;
        entry_next.na = na_next;
        entry_next.den = den_next;
        entry_next.dax = f2_dax_reg;
        entry_next.day = f2_day_reg;
        entry_next.ax0 = f2_ax0_reg;
        entry_next.ay0 = f2_ay0_reg;
    end

endmodule

### hdl/seg_queue.sv
module seg_queue #(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  seg_pkg::entry_t push_entry,
    output logic not_full,
    input  logic pop,
    output logic not_empty,
    output seg_pkg::entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    seg_pkg::entry_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_full = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> not_full)
        else $error("Queue written while full.");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("Queue read while empty.");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("Queue count exceeds depth.");

endmodule

### hdl/seg_div.sv
module seg_div
(
    input  logic clk,
    input  logic en,
    input  logic [seg_pkg::NUM_W-1:0] num_mag,
    input  logic [seg_pkg::SUM_W-1:0] den_mag,
    input  logic neg,
    output logic signed [seg_pkg::QUOT_W:0] quot
);

    localparam int N = seg_pkg::QUOT_W;
    localparam int RW = seg_pkg::SUM_W;

    logic [RW-1:0] rem_reg [N+1];
    logic [N-1:0] low_reg [N+1];
    logic [N-1:0] q_reg [N+1];
    logic [RW-1:0] den_reg [N+1];
    logic neg_reg [N+1];

    always_comb
    begin
        rem_reg[0] = num_mag[N+RW-1:N];
        low_reg[0] = num_mag[N-1:0];
        q_reg[0] = '0;
        den_reg[0] = den_mag;
        neg_reg[0] = neg;
    end

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [RW:0] sh;
        logic ge;
        assign sh = {rem_reg[s], low_reg[s][N-1]};
        assign ge = (sh >= {1'b0, den_reg[s]});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= ge ? RW'(sh - {1'b0, den_reg[s]}) : sh[RW-1:0];
                low_reg[s+1] <= {low_reg[s][N-2:0], 1'b0};
                q_reg[s+1] <= {q_reg[s][N-2:0], ge};
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    assign quot = neg_reg[N] ? -$signed({1'b0, q_reg[N]}) : $signed({1'b0, q_reg[N]});

endmodule

### hdl/seg_back.sv
module seg_back
(
    input  logic clk,
    input  logic rst_n,
    input  logic not_empty,
    input  seg_pkg::entry_t pop_entry,
    output logic pop,
    output logic out_valid,
    input  logic out_ready,
    output logic [1:0] hit_status,
    output logic signed [23:0] point_x,
    output logic signed [23:0] point_y
);

    localparam int N = seg_pkg::QUOT_W;
    localparam int L = N + 2;

    logic en;
    logic signed [seg_pkg::MUL_W-1:0] mx_reg, my_reg;
    logic signed [seg_pkg::SUM_W-1:0] den_reg;
    logic [seg_pkg::MUL_W-1:0] magx_reg, magy_reg;
    logic [seg_pkg::SUM_W-1:0] dmag_reg;
    logic negx_reg, negy_reg;
    logic signed [seg_pkg::QUOT_W:0] qx, qy;

    logic valid_reg [L+1];
    logic [1:0] status_reg [L+1];
    logic signed [seg_pkg::COORD_W-1:0] ax0_reg [L+1];
    logic signed [seg_pkg::COORD_W-1:0] ay0_reg [L+1];

    logic out_valid_reg;
    logic [1:0] status_out_reg;
    logic signed [seg_pkg::POINT_W-1:0] px_reg, py_reg, px_next, py_next;
    logic signed [seg_pkg::POINT_W+1:0] sx, sy;

    assign en = !out_valid_reg || out_ready;
    assign pop = en && not_empty;

    always_comb
    begin
        valid_reg[0] = not_empty;
        status_reg[0] = pop_entry.status;
        ax0_reg[0] = pop_entry.ax0;
        ay0_reg[0] = pop_entry.ay0;
    end

    for (genvar s = 0; s < L; s++)
    begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s+1] <= 1'b0;
            else if (en)
                valid_reg[s+1] <= valid_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                status_reg[s+1] <= status_reg[s];
                ax0_reg[s+1] <= ax0_reg[s];
                ay0_reg[s+1] <= ay0_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= seg_pkg::MUL_W'(pop_entry.na) * seg_pkg::MUL_W'(pop_entry.dax);
            my_reg <= seg_pkg::MUL_W'(pop_entry.na) * seg_pkg::MUL_W'(pop_entry.day);
            den_reg <= pop_entry.den;
            magx_reg <= mx_reg[seg_pkg::MUL_W-1] ? -mx_reg : mx_reg;
            magy_reg <= my_reg[seg_pkg::MUL_W-1] ? -my_reg : my_reg;
            dmag_reg <= den_reg[seg_pkg::SUM_W-1] ? -den_reg : den_reg;
            negx_reg <= mx_reg[seg_pkg::MUL_W-1] ^ den_reg[seg_pkg::SUM_W-1];
            negy_reg <= my_reg[seg_pkg::MUL_W-1] ^ den_reg[seg_pkg::SUM_W-1];
        end
    end

    seg_div u_div_x
    (
        .clk(clk),
        .en(en),
        .num_mag({magx_reg, {seg_pkg::FRAC_BITS{1'b0}}}),
        .den_mag(dmag_reg),
        .neg(negx_reg),
        .quot(qx)
    );

    seg_div u_div_y
    (
        .clk(clk),
        .en(en),
        .num_mag({magy_reg, {seg_pkg::FRAC_BITS{1'b0}}}),
        .den_mag(dmag_reg),
        .neg(negy_reg),
        .quot(qy)
    );

    always_comb
    begin
        sx = {{2{ax0_reg[L][15]}}, ax0_reg[L], {seg_pkg::FRAC_BITS{1'b0}}} + {qx[N], qx};
        sy = {{2{ay0_reg[L][15]}}, ay0_reg[L], {seg_pkg::FRAC_BITS{1'b0}}} + {qy[N], qy};
        if (status_reg[L] == seg_pkg::STATUS_HIT)
        begin
            px_next = sx[seg_pkg::POINT_W-1:0];
            py_next = sy[seg_pkg::POINT_W-1:0];
        end
        else
        begin
            px_next = '0;
            py_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_reg[L];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_out_reg <= status_reg[L];
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit_status = status_out_reg;
    assign point_x = px_reg;
    assign point_y = py_reg;

endmodule

### hdl/segment_intersection.sv
// An item passes three front stages, the queue register, a product stage, a magnitude
// stage, 24 divider stages and the output register. Throughput is one item per cycle
// unless out_ready or a full queue stalls; the two 24-stage quotient pipelines set the depth.
// Reset clears all valid flags and the queue pointers; no item is held after reset.
module segment_intersection #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [15:0] ax0,
    input  logic signed [15:0] ay0,
    input  logic signed [15:0] ax1,
    input  logic signed [15:0] ay1,
    input  logic signed [15:0] bx0,
    input  logic signed [15:0] by0,
    input  logic signed [15:0] bx1,
    input  logic signed [15:0] by1,
    output logic out_valid,
    input  logic out_ready,
    output logic [1:0] hit_status,
    output logic signed [23:0] point_x,
    output logic signed [23:0] point_y
);

    logic push, pop, not_full, not_empty;
    seg_pkg::entry_t push_entry, pop_entry;

    seg_front u_front
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .ax0(ax0),
        .ay0(ay0),
        .ax1(ax1),
        .ay1(ay1),
        .bx0(bx0),
        .by0(by0),
        .bx1(bx1),
        .by1(by1),
        .push(push),
        .push_entry(push_entry),
        .queue_ready(not_full)
    );

    seg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_entry(push_entry),
        .not_full(not_full),
        .pop(pop),
        .not_empty(not_empty),
        .pop_entry(pop_entry)
    );

    seg_back u_back
    (
        .clk(clk),
        .rst_n(rst_n),
        .not_empty(not_empty),
        .pop_entry(pop_entry),
        .pop(pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .hit_status(hit_status),
        .point_x(point_x),
        .point_y(point_y)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit_status == seg_pkg::STATUS_HIT) ||
        (hit_status == seg_pkg::STATUS_PARALLEL) || (hit_status == seg_pkg::STATUS_MISS))
        else $error("Result status code out of range.");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (hit_status != seg_pkg::STATUS_HIT) |-> (point_x == 0) && (point_y == 0))
        else $error("Nonzero point on a result without a hit.");

endmodule

### tb/segment_checker.sv
module segment_checker
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  logic signed [15:0] ax0,
    input  logic signed [15:0] ay0,
    input  logic signed [15:0] ax1,
    input  logic signed [15:0] ay1,
    input  logic signed [15:0] bx0,
    input  logic signed [15:0] by0,
    input  logic signed [15:0] bx1,
    input  logic signed [15:0] by1,
    input  logic out_valid,
    input  logic out_ready,
    input  logic [1:0] hit_status,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    output int errors,
    output int pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] status;
        logic [23:0] px;
        logic [23:0] py;
    } crossing_t;

    crossing_t crossings_due[$];

    function automatic bit ratio_in_unit(longint num, longint den);
        if (den > 0)
            return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    function automatic crossing_t find_crossing(longint a0x, longint a0y, longint a1x,
                                                longint a1y, longint b0x, longint b0y,
                                                longint b1x, longint b1y);
        longint dax, day, dbx, dby, ox, oy, den, na, nb, px, py;
        crossing_t c;
        dax = a1x - a0x;
        day = a1y - a0y;
        dbx = b1x - b0x;
        dby = b1y - b0y;
        ox = a0x - b0x;
        oy = a0y - b0y;
        den = dby * dax - dbx * day;
        na = dbx * oy - dby * ox;
        nb = dax * oy - day * ox;
        px = 0;
        py = 0;
        if (den == 0)
            c.status = seg_pkg::STATUS_PARALLEL;
        else if (ratio_in_unit(na, den) && ratio_in_unit(nb, den))
        begin
            c.status = seg_pkg::STATUS_HIT;
            px = a0x * 256 + (na * dax * 256) / den;
            py = a0y * 256 + (na * day * 256) / den;
        end
        else
            c.status = seg_pkg::STATUS_MISS;
        c.px = px[23:0];
        c.py = py[23:0];
        return c;
    endfunction

    assign pending = crossings_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        crossing_t e;
        if (!rst_n)
            errors <= 0;
        else
        begin
            if (in_valid && in_ready)
                crossings_due.push_back(find_crossing(ax0, ay0, ax1, ay1,
                                                      bx0, by0, bx1, by1));
            if (out_valid && out_ready)
            begin
                if (crossings_due.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d x %0d y %0d", $realtime,
                             hit_status, point_x, point_y);
                    errors <= errors + 1;
                end
                else
                begin
                    e = crossings_due.pop_front();
                    if (hit_status !== e.status || point_x !== e.px || point_y !== e.py)
                    begin
                        $display("%0t: expected status %0d x %0d y %0d, got %0d x %0d y %0d",
                                 $realtime, e.status, $signed(e.px), $signed(e.py),
                                 hit_status, point_x, point_y);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/tb_segment_intersection.sv
module tb_segment_intersection;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0, rst_n = 0, in_valid = 0, out_ready = 0;
    logic in_ready, out_valid;
    logic signed [15:0] ax0 = 0, ay0 = 0, ax1 = 0, ay1 = 0;
    logic signed [15:0] bx0 = 0, by0 = 0, bx1 = 0, by1 = 0;
    logic [1:0] hit_status;
    logic signed [23:0] point_x, point_y;
    int errors, pending;
    int cycle_count = 0;
    bit calm = 0;
    bit hold_off = 0;
    bit pressure_go = 0;

    segment_intersection uut (.*);

    segment_checker chk (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            out_ready <= 0;
        else
            out_ready <= calm || $urandom_range(99) >= 32;
    end

    function automatic logic signed [15:0] pick_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return $signed(16'($urandom_range(40))) - 16'sd20;
            default: return $urandom_range(3) == 0 ? 16'sh8000 : 16'sh7fff;
        endcase
    endfunction

    task automatic offer_pair(logic signed [15:0] c[8]);
        while (!calm && $urandom_range(99) < 32)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        ax0 <= c[0]; ay0 <= c[1]; ax1 <= c[2]; ay1 <= c[3];
        bx0 <= c[4]; by0 <= c[5]; bx1 <= c[6]; by1 <= c[7];
        in_valid <= 1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    initial
    begin
        logic signed [15:0] c[8];
        int mode;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        c = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
              16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
        offer_pair(c);
        c = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
              16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};
        offer_pair(c);
        c = '{0, 0, 10, 0, 0, 5, 10, 5};
        offer_pair(c);
        c = '{0, 0, 10, 0, 2, 0, 8, 0};
        offer_pair(c);
        c = '{3, 3, 3, 3, 0, 0, 5, 5};
        offer_pair(c);
        c = '{0, 0, 10, 10, 0, 10, 10, 0};
        offer_pair(c);
        c = '{0, 0, 10, 0, 10, -5, 10, 5};
        offer_pair(c);
        c = '{0, 0, 10, 0, 11, -5, 11, 5};
        offer_pair(c);
        c = '{0, 0, 3, 7, 1, 5, 2, -4};
        offer_pair(c);
        c = '{-1, -1, -1, -1, -1, -1, -1, -1};
        offer_pair(c);
        pressure_go = 1;
        for (int i = 0; i < 60; i++)
        begin
            foreach (c[k]) c[k] = pick_coord(1);
            offer_pair(c);
        end
        for (int i = 0; i < 430; i++)
        begin
            calm = (i >= 200 && i < 260);
            mode = $urandom_range(9);
            if (mode < 6)
            begin
                foreach (c[k]) c[k] = pick_coord(mode < 3 ? 1 : 0);
                c[4] = c[0] + (c[2] - c[0]) / 2 - 16'($urandom_range(6)) + 16'sd3;
                c[5] = c[1] + (c[3] - c[1]) / 2 - 16'($urandom_range(6)) + 16'sd3;
                c[6] = c[4] + 16'($urandom_range(100)) - 16'sd50;
                c[7] = c[5] + 16'($urandom_range(100)) - 16'sd50;
            end
            else
                foreach (c[k]) c[k] = pick_coord(mode - 6);
            offer_pair(c);
        end
        in_valid <= 0;
        calm = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // The receiver stops taking results for a fixed stretch so the block fills up.
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1;
        repeat (150) @(posedge clk);
        hold_off <= 0;
    end
endmodule

### segment_intersection.f
hdl/seg_pkg.sv
hdl/seg_front.sv
hdl/seg_queue.sv
hdl/seg_div.sv
hdl/seg_back.sv
hdl/segment_intersection.sv
tb/segment_checker.sv
tb/tb_segment_intersection.sv
